// File: rtl/pclru_pkg.sv
`default_nettype none

package pclru_pkg;

  localparam int unsigned MAX_SLOTS  = 256;
  localparam int unsigned SLOT_AW    = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W      = SLOT_AW + 1;
  localparam int unsigned TAG_W      = 36;
  localparam int unsigned STAMP_W    = 64;
  localparam int unsigned SIDE_W     = 5;
  localparam int unsigned COORD_W    = 4;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 5'd16;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_TOUCH  = 2'd1;
  localparam logic [1:0] OP_ALLOC  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] page_x;
    logic [11:0] page_y;
    logic [3:0]  page_mip;
    logic [7:0]  texture_id;
    logic [63:0] frame;
  } pclru_in_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  slot_x;
    logic [3:0]  slot_y;
    logic        evicted;
    logic [11:0] evicted_x;
    logic [11:0] evicted_y;
    logic [3:0]  evicted_mip;
    logic [7:0]  evicted_texture;
  } pclru_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } pclru_state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
  } pclru_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } pclru_status_t;

  // Largest pool coordinate for a programmed side; zero acts as one, above 16 as 16.
  function automatic logic [COORD_W-1:0] side_m1_f(input logic [SIDE_W-1:0] side);
    logic [SIDE_W-1:0] t;
    t = side - 5'd1;
    if (side == 5'd0) begin
      return 4'd0;
    end
    if (side > 5'd16) begin
      return 4'd15;
    end
    return t[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/pclru_ctrl.sv
`default_nettype none

module pclru_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire pclru_pkg::pclru_status_t status,
  output pclru_pkg::pclru_cmd_t        cmd
);
  import pclru_pkg::*;

  pclru_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    cmd.start  = 1'b0;
    cmd.scan   = 1'b0;
    cmd.finish = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = status.out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/pclru_dp.sv
`default_nettype none

module pclru_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [pclru_pkg::SIDE_W-1:0]     cfg_wr_data,
  input  wire pclru_pkg::pclru_in_t             in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output pclru_pkg::pclru_out_t                 out_data,
  input  wire pclru_pkg::pclru_cmd_t            cmd,
  output pclru_pkg::pclru_status_t              status
);
  import pclru_pkg::*;

  logic [TAG_W-1:0]   tag_mem [MAX_SLOTS];
  logic [STAMP_W-1:0] lu_mem  [MAX_SLOTS];

  pclru_in_t          req_r;
  logic [SIDE_W-1:0]  pool_side_r;
  logic [MAX_SLOTS-1:0] occ_r;
  logic [CNT_W-1:0]   taken_r;
  logic [COORD_W-1:0] fx_r, fy_r;

  logic [CNT_W-1:0]   cnt_r;
  logic [COORD_W-1:0] sc_col_r, sc_row_r;
  logic               rd_v_r;
  logic [SLOT_AW-1:0] rd_idx_r;
  logic [COORD_W-1:0] rd_col_r, rd_row_r;
  logic               rd_occ_r;
  logic [TAG_W-1:0]   tag_q_r;
  logic [STAMP_W-1:0] lu_q_r;

  logic               found_r;
  logic [SLOT_AW-1:0] hit_idx_r;
  logic [COORD_W-1:0] hit_col_r, hit_row_r;
  logic [STAMP_W-1:0] best_r;
  logic [SLOT_AW-1:0] vic_idx_r;
  logic [COORD_W-1:0] vic_col_r, vic_row_r;
  logic [TAG_W-1:0]   vic_tag_r;

  logic               out_valid_r;
  pclru_out_t         out_data_r, out_nxt;

  logic [COORD_W-1:0] side_m1;
  logic [SIDE_W-1:0]  side_w;
  logic [9:0]         n_full;
  logic [CNT_W-1:0]   n_w;
  logic [CNT_W-1:0]   free_full;
  logic [SLOT_AW-1:0] free_idx;
  logic [TAG_W-1:0]   req_tag;
  logic               issue, has_free, is_clear, miss_alloc, alloc_free, evict;
  logic               tag_we, lu_we, fin;
  logic [SLOT_AW-1:0] wr_idx;

  assign side_m1   = side_m1_f(pool_side_r);
  assign side_w    = {1'b0, side_m1} + 5'd1;
  assign n_full    = side_w * side_w;
  assign n_w       = n_full[CNT_W-1:0];
  assign free_full = n_w - 9'd1 - taken_r;
  assign free_idx  = free_full[SLOT_AW-1:0];
  assign req_tag   = {req_r.texture_id, req_r.page_mip, req_r.page_y, req_r.page_x};

  assign fin        = cmd.finish;
  assign issue      = cmd.scan && (cnt_r < n_w);
  assign is_clear   = (req_r.opcode == OP_CLEAR);
  assign has_free   = (taken_r < n_w);
  assign miss_alloc = !found_r && (req_r.opcode == OP_ALLOC);
  assign alloc_free = miss_alloc && has_free;
  assign evict      = miss_alloc && !has_free;
  assign wr_idx     = found_r ? hit_idx_r : (alloc_free ? free_idx : vic_idx_r);
  assign tag_we     = fin && miss_alloc;
  assign lu_we      = fin && ((found_r && (req_r.opcode != OP_LOOKUP)) || miss_alloc);

  assign status.scan_done = is_clear || ((cnt_r == n_w) && !rd_v_r);
  assign status.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[wr_idx] <= req_tag;
    end
    if (issue) begin
      tag_q_r <= tag_mem[cnt_r[SLOT_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (lu_we) begin
      lu_mem[wr_idx] <= req_r.frame;
    end
    if (issue) begin
      lu_q_r <= lu_mem[cnt_r[SLOT_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_side_r <= SIDE_RESET;
      occ_r       <= '0;
      taken_r     <= '0;
      fx_r        <= side_m1_f(SIDE_RESET);
      fy_r        <= side_m1_f(SIDE_RESET);
    end else if (cfg_wr_en) begin
      pool_side_r <= cfg_wr_data;
      occ_r       <= '0;
      taken_r     <= '0;
      fx_r        <= side_m1_f(cfg_wr_data);
      fy_r        <= side_m1_f(cfg_wr_data);
    end else if (fin) begin
      if (is_clear) begin
        occ_r   <= '0;
        taken_r <= '0;
        fx_r    <= side_m1;
        fy_r    <= side_m1;
      end else if (miss_alloc) begin
        occ_r[wr_idx] <= 1'b1;
        if (has_free) begin
          taken_r <= taken_r + 9'd1;
          if (fx_r == 4'd0) begin
            fx_r <= side_m1;
            fy_r <= fy_r - 4'd1;
          end else begin
            fx_r <= fx_r - 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      rd_v_r  <= 1'b0;
      found_r <= 1'b0;
    end else if (cmd.start) begin
      cnt_r   <= '0;
      rd_v_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      rd_v_r <= issue;
      if (issue) begin
        cnt_r <= cnt_r + 9'd1;
      end
      if (rd_v_r && rd_occ_r && (tag_q_r == req_tag) && !found_r) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sc_col_r  <= '0;
      sc_row_r  <= '0;
      best_r    <= '1;
      vic_idx_r <= '0;
      vic_col_r <= '0;
      vic_row_r <= '0;
    end else begin
      if (issue) begin
        rd_idx_r <= cnt_r[SLOT_AW-1:0];
        rd_col_r <= sc_col_r;
        rd_row_r <= sc_row_r;
        rd_occ_r <= occ_r[cnt_r[SLOT_AW-1:0]];
        if (sc_col_r == side_m1) begin
          sc_col_r <= '0;
          sc_row_r <= sc_row_r + 4'd1;
        end else begin
          sc_col_r <= sc_col_r + 4'd1;
        end
      end
      if (rd_v_r) begin
        if (rd_occ_r && (tag_q_r == req_tag) && !found_r) begin
          hit_idx_r <= rd_idx_r;
          hit_col_r <= rd_col_r;
          hit_row_r <= rd_row_r;
        end
        if (rd_idx_r == '0) begin
          vic_tag_r <= tag_q_r;
        end
        if (rd_occ_r && (lu_q_r < best_r)) begin
          best_r    <= lu_q_r;
          vic_idx_r <= rd_idx_r;
          vic_col_r <= rd_col_r;
          vic_row_r <= rd_row_r;
          vic_tag_r <= tag_q_r;
        end
      end
    end
  end

  always_comb begin
    out_nxt = '0;
    if (!is_clear) begin
      if (found_r) begin
        out_nxt.hit    = 1'b1;
        out_nxt.slot_x = hit_col_r;
        out_nxt.slot_y = hit_row_r;
      end else if (alloc_free) begin
        out_nxt.slot_x = fx_r;
        out_nxt.slot_y = fy_r;
      end else if (evict) begin
        out_nxt.slot_x          = vic_col_r;
        out_nxt.slot_y          = vic_row_r;
        out_nxt.evicted         = 1'b1;
        out_nxt.evicted_x       = vic_tag_r[11:0];
        out_nxt.evicted_y       = vic_tag_r[23:12];
        out_nxt.evicted_mip     = vic_tag_r[27:24];
        out_nxt.evicted_texture = vic_tag_r[35:28];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
    taken_r <= n_w)
    else $error("slot fill count exceeds pool size");

  a_free_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fin && alloc_free |-> !occ_r[free_idx])
    else $error("free slot already occupied");

  a_victim_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    fin && evict |-> occ_r[vic_idx_r])
    else $error("eviction victim not occupied");

  a_hit_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    fin && found_r |-> occ_r[hit_idx_r])
    else $error("hit slot not occupied");

endmodule

`default_nettype wire

// File: rtl/page_cache_lru_allocator.sv
`default_nettype none

// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   pclru_in_t (opcode, page id, frame)
// out_      output     out_valid/out_stall pclru_out_t (hit, slot, evicted page id)
// cfg_      input      cfg_wr_en           cfg_wr_data (pool_side)
//
// A lookup, touch or allocate item is accepted, then the tag and stamp memories are scanned
// one slot per cycle over n = side * side slots for the match and the LRU victim, and then
// the item is written back; its result is loaded into the output register at write-back.
// A clear item does not wait for a scan and goes straight on to write-back.
// Synchronous reset empties every slot at once; no clearing pass is needed.
// A finished item waits in the output register while out_stall is high, and the write-back
// of the next item waits until that register is free.

module page_cache_lru_allocator (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire pclru_pkg::pclru_in_t         in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output pclru_pkg::pclru_out_t             out_data,
  input  wire logic                         cfg_wr_en,
  input  wire logic [pclru_pkg::SIDE_W-1:0] cfg_wr_data
);
  import pclru_pkg::*;

  pclru_cmd_t    cmd;
  pclru_status_t status;

  pclru_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pclru_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

`default_nettype wire

// File: test/page_cache_lru_allocator_tb.sv
`default_nettype none

module page_cache_lru_allocator_tb;
  import pclru_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 300;
  localparam int NUM_PHASES = 10;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  class pool_scoreboard;
    bit [SIDE_W-1:0] side_reg;
    bit [TAG_W-1:0] page_tag [MAX_SLOTS];
    bit [STAMP_W-1:0] last_used [MAX_SLOTS];
    bit resident [MAX_SLOTS];
    int unsigned taken;
    pclru_out_t pending_replies [$];
    int unsigned mismatches;
    int unsigned items;
    int unsigned replies;
    int unsigned hits;
    int unsigned evictions;
    int unsigned clears;

    function new();
      side_reg = SIDE_RESET;
      mismatches = 0;
      items = 0;
      replies = 0;
      hits = 0;
      evictions = 0;
      clears = 0;
      empty_pool();
    endfunction

    function void empty_pool();
      foreach (resident[i]) resident[i] = 1'b0;
      taken = 0;
    endfunction

    function void write_side(bit [SIDE_W-1:0] value);
      side_reg = value;
      empty_pool();
    endfunction

    function int unsigned side_now();
      if (side_reg == 0) return 1;
      if (side_reg > 16) return 16;
      return side_reg;
    endfunction

    function void report(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endfunction

    function void queue_reply(pclru_out_t r);
      pending_replies = {pending_replies, r};
    endfunction

    function void note_item(pclru_in_t it);
      pclru_out_t reply;
      bit [TAG_W-1:0] key;
      bit [STAMP_W-1:0] best;
      int unsigned s;
      int unsigned n;
      int unsigned slot;
      int unsigned i;
      bit found;
      reply = '0;
      key = {it.texture_id, it.page_mip, it.page_y, it.page_x};
      s = side_now();
      n = s * s;
      slot = 0;
      found = 1'b0;
      items++;
      if (it.opcode == OP_CLEAR) begin
        clears++;
        empty_pool();
        queue_reply(reply);
        return;
      end
      for (i = 0; i < n; i++) begin
        if (resident[i] && page_tag[i] == key) begin
          slot = i;
          found = 1'b1;
          break;
        end
      end
      if (found) begin
        hits++;
        if (it.opcode != OP_LOOKUP) last_used[slot] = it.frame;
      end else if (it.opcode == OP_ALLOC) begin
        if (taken < n) begin
          slot = n - 1 - taken;
          taken++;
        end else begin
          best = '1;
          slot = 0;
          for (i = 0; i < n; i++) begin
            if (resident[i] && last_used[i] < best) begin
              best = last_used[i];
              slot = i;
            end
          end
          evictions++;
          reply.evicted = 1'b1;
          {reply.evicted_texture, reply.evicted_mip, reply.evicted_y, reply.evicted_x} =
            page_tag[slot];
        end
        resident[slot] = 1'b1;
        page_tag[slot] = key;
        last_used[slot] = it.frame;
      end else begin
        queue_reply(reply);
        return;
      end
      reply.hit = found;
      reply.slot_x = COORD_W'(slot % s);
      reply.slot_y = COORD_W'(slot / s);
      queue_reply(reply);
    endfunction

    function void compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
        report($sformatf("result %0d %s: got %0h, expected %0h", replies, name, got, want));
      end
    endfunction

    function void check_result(pclru_out_t got);
      pclru_out_t want;
      replies++;
      if (pending_replies.size() == 0) begin
        report($sformatf("result %0d arrived with no item pending", replies));
        return;
      end
      want = pending_replies.pop_front();
      compare_field("hit", got.hit, want.hit);
      compare_field("slot_x", got.slot_x, want.slot_x);
      compare_field("slot_y", got.slot_y, want.slot_y);
      compare_field("evicted", got.evicted, want.evicted);
      compare_field("evicted_x", got.evicted_x, want.evicted_x);
      compare_field("evicted_y", got.evicted_y, want.evicted_y);
      compare_field("evicted_mip", got.evicted_mip, want.evicted_mip);
      compare_field("evicted_texture", got.evicted_texture, want.evicted_texture);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  pclru_in_t in_data;
  logic out_valid;
  logic out_stall;
  pclru_out_t out_data;
  logic cfg_wr_en;
  logic [SIDE_W-1:0] cfg_wr_data;

  pool_scoreboard sb;
  idle_mode_t idle_mode;
  int unsigned quiet_cycles;
  int unsigned settings_used;
  bit [63:0] cur_frame;
  bit [TAG_W-1:0] recent_pages [$];

  int phase_side [NUM_PHASES] = '{3, 2, 0, 5, 16, 4, 31, 17, 1, 7};
  idle_mode_t phase_mode [NUM_PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                          IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                          IDLE_NONE, IDLE_RECV};
  int phase_items [NUM_PHASES] = '{60, 50, 40, 60, 25, 60, 20, 15, 30, 60};

  page_cache_lru_allocator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit sender_rests();
    if (idle_mode == IDLE_SEND) return $urandom_range(99) < 78;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 34;
    return 1'b0;
  endfunction

  function automatic bit receiver_stalls();
    if (idle_mode == IDLE_RECV) return $urandom_range(99) < 78;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 34;
    return 1'b0;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall = 1'b0;
    end else begin
      out_stall = receiver_stalls();
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_item(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(input pclru_in_t it);
    @(negedge clk);
    while (sender_rests()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_page(input logic [1:0] op, input logic [11:0] x, input logic [11:0] y,
                           input logic [3:0] mip, input logic [7:0] tex,
                           input logic [63:0] frame);
    pclru_in_t it;
    it.opcode = op;
    it.page_x = x;
    it.page_y = y;
    it.page_mip = mip;
    it.texture_id = tex;
    it.frame = frame;
    send_item(it);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_side(input logic [SIDE_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.write_side(value);
    recent_pages.delete();
    settings_used++;
  endtask

  function automatic bit [63:0] next_frame();
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick < 14) begin
      cur_frame = cur_frame + 64'($urandom_range(3));
    end else if (pick < 16) begin
      cur_frame = {$urandom, $urandom};
    end else if (pick < 18) begin
      return 64'($urandom_range(15));
    end else if (pick < 19) begin
      return '1;
    end
    return cur_frame;
  endfunction

  task automatic send_random(input int unsigned n_slots);
    pclru_in_t it;
    bit [TAG_W-1:0] key;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      it.opcode = OP_LOOKUP;
    end else if (pick < 45) begin
      it.opcode = OP_TOUCH;
    end else if (pick < 97) begin
      it.opcode = OP_ALLOC;
    end else begin
      it.opcode = OP_CLEAR;
    end
    pick = $urandom_range(99);
    if (recent_pages.size() != 0 && pick < 50) begin
      key = recent_pages[$urandom_range(recent_pages.size() - 1)];
      // A single flipped bit gives a near miss on the tag compare.
      if (pick < 8) key[$urandom_range(TAG_W - 1)] ^= 1'b1;
    end else begin
      key = TAG_W'({$urandom, $urandom});
    end
    {it.texture_id, it.page_mip, it.page_y, it.page_x} = key;
    it.frame = next_frame();
    if (it.opcode == OP_ALLOC) begin
      recent_pages = {recent_pages, key};
      if (recent_pages.size() > 2 * n_slots + 4) void'(recent_pages.pop_front());
    end
    send_item(it);
  endtask

  initial begin
    int p;
    int k;
    int unsigned side;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    idle_mode = IDLE_NONE;
    quiet_cycles = 0;
    settings_used = 1;
    cur_frame = 64'd100;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_page(OP_ALLOC, 12'd1, 12'd2, 4'd3, 8'd4, 64'd10);
    send_page(OP_LOOKUP, 12'd1, 12'd2, 4'd3, 8'd4, 64'd11);
    send_page(OP_LOOKUP, 12'd5, 12'd2, 4'd3, 8'd4, 64'd12);
    send_page(OP_TOUCH, 12'd5, 12'd2, 4'd3, 8'd4, 64'd13);
    send_page(OP_TOUCH, 12'd1, 12'd2, 4'd3, 8'd4, 64'd20);
    send_page(OP_ALLOC, 12'd1, 12'd2, 4'd3, 8'd4, 64'd30);
    send_page(OP_ALLOC, 12'hFFF, 12'hFFF, 4'hF, 8'hFF, 64'd0);
    send_page(OP_CLEAR, 12'hFFF, 12'hFFF, 4'hF, 8'hFF, '1);
    send_page(OP_LOOKUP, 12'd1, 12'd2, 4'd3, 8'd4, 64'd31);

    write_side(5'd1);
    send_page(OP_ALLOC, 12'hFFF, 12'hFFF, 4'hF, 8'hFF, '1);
    send_page(OP_ALLOC, 12'd0, 12'd0, 4'd0, 8'd0, '1);
    send_page(OP_LOOKUP, 12'd0, 12'd0, 4'd0, 8'd0, 64'd0);

    // All stamps at the maximum frame leave slot zero as the victim.
    write_side(5'd2);
    for (k = 0; k < 4; k++) begin
      send_page(OP_ALLOC, 12'(k + 16), 12'(k * 3), 4'(k), 8'(k + 1), '1);
    end
    send_page(OP_ALLOC, 12'd40, 12'd41, 4'd2, 8'd9, 64'd5);
    send_page(OP_TOUCH, 12'd16, 12'd0, 4'd0, 8'd1, 64'd1);
    send_page(OP_ALLOC, 12'd50, 12'd51, 4'd7, 8'd200, 64'd7);

    write_side(5'd0);
    send_page(OP_ALLOC, 12'h800, 12'h001, 4'h8, 8'h80, 64'h8000_0000_0000_0000);
    send_page(OP_ALLOC, 12'h001, 12'h800, 4'h1, 8'h01, 64'h8000_0000_0000_0000);

    for (p = 0; p < NUM_PHASES; p++) begin
      write_side(5'(phase_side[p]));
      idle_mode = phase_mode[p];
      side = sb.side_now();
      for (k = 0; k < phase_items[p]; k++) begin
        if (p == 3 && k == 30) drain_results();
        send_random(side * side);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d items over %0d pool settings: %0d hits, %0d evictions, %0d clears.",
             sb.items, settings_used, sb.hits, sb.evictions, sb.clears);
    $display("%0d results checked, %0d mismatches.", sb.replies, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
